// ----- hdl/vdi_pkg.sv -----
package vdi_pkg;

    localparam int COORD_W = 32;
    localparam int TOL_W   = 17;
    localparam int IDX_W   = 8;

    // One stored vertex: x in the low half, y in the high half
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vertex;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

endpackage

// ----- hdl/vdi_store.sv -----
module vdi_store
    import vdi_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int AW           = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_vertex       i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_vertex       o_rdata
);

    t_vertex mem [MAX_VERTICES];
    t_vertex r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/vdi_match.sv -----
module vdi_match
    import vdi_pkg::*;
(
    input  t_vertex          i_point,
    input  t_vertex          i_stored,
    input  logic [TOL_W-1:0] i_tol,
    output logic             o_match
);

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic        [COORD_W:0] adx;
    logic        [COORD_W:0] ady;
    logic        [COORD_W:0] tol_ext;

    // Exact 33-bit differences, no wraparound
    assign dx = {i_point.x[COORD_W-1], i_point.x} - {i_stored.x[COORD_W-1], i_stored.x};
    assign dy = {i_point.y[COORD_W-1], i_point.y} - {i_stored.y[COORD_W-1], i_stored.y};

    assign adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
    assign ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);

    assign tol_ext = (COORD_W+1)'(i_tol);

    assign o_match = (adx < tol_ext) && (ady < tol_ext);

endmodule

// ----- hdl/vertex_dedup_indexer_top.sv -----
// Vertex welding indexer. Each accepted item (start high while busy is low)
// carries one signed Q16.16 point. The stored vertices are scanned from index
// 0 upward, one entry per cycle out of a synchronous store with a registered
// read port, for the first whose x and y each lie strictly within
// match_tolerance of the point; its index is returned. With no match the point
// is appended at the next free index (is_new set), or, with the store full,
// overflow is raised and index 0 returned. An item keeps busy high until a
// stored entry matches or the last one has missed, behind the registered read
// port; with the store empty no entry is read, and a full scan is the worst
// case. The result appears on the o_ ports with o_result_valid for exactly
// one cycle, the first cycle in which busy is low again; the receiver cannot
// stall it, and a new item may be started in that same cycle.
// The tolerance register (reset 1, exact match only) is written through
// i_cfg_valid/o_cfg_ready, which is always ready; write it only while idle.
// The store needs no clearing: only entries below the vertex count are read.
module vertex_dedup_indexer_top
    import vdi_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // item channel
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    // result channel
    output logic                      o_result_valid,
    output logic        [IDX_W-1:0]   o_vertex_index,
    output logic                      o_is_new,
    output logic                      o_overflow,
    // tolerance register
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic        [TOL_W-1:0]   i_cfg_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_VERTICES);

    t_state           r_state, n_state;
    t_vertex          r_point;
    logic [TOL_W-1:0] r_tol;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;   // next entry to read
    logic [AW-1:0]    r_cmp_idx, n_cmp_idx; // entry whose data is on the store output
    logic             r_dv, n_dv;           // store output holds a scanned entry

    logic             r_res_valid, n_res_valid;
    logic [IDX_W-1:0] r_res_index, n_res_index;
    logic             r_res_new, n_res_new;
    logic             r_res_ovf, n_res_ovf;

    logic             rd_en;
    logic             wr_en;
    t_vertex          rdata;
    logic             hit;
    logic             last_cmp;
    logic             scan_end;
    logic             full;

    vdi_store #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_point),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    vdi_match u_match (
        .i_point  (r_point),
        .i_stored (rdata),
        .i_tol    (r_tol),
        .o_match  (hit)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign full     = (r_count == FULL_COUNT);
    assign last_cmp = (CW'(r_cmp_idx) == (r_count - CW'(1)));
    assign rd_en    = (r_state == ST_SCAN) && (r_rd_idx < r_count);
    // no match anywhere: empty store, or the last entry just missed
    assign scan_end = (r_state == ST_SCAN) &&
                      ((r_count == '0) || (r_dv && !hit && last_cmp));
    // the appended entry lies beyond the scanned range, so no read can clash
    assign wr_en    = scan_end && !full;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_dv        = 1'b0;
        n_res_valid = 1'b0;
        n_res_index = r_res_index;
        n_res_new   = r_res_new;
        n_res_ovf   = r_res_ovf;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state  = ST_SCAN;
                    n_rd_idx = '0;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_dv      = 1'b1;
                    n_cmp_idx = r_rd_idx[AW-1:0];
                    n_rd_idx  = r_rd_idx + CW'(1);
                end
                if (r_dv && hit) begin
                    n_state     = ST_IDLE;
                    n_dv        = 1'b0;
                    n_res_valid = 1'b1;
                    n_res_index = IDX_W'(r_cmp_idx);
                    n_res_new   = 1'b0;
                    n_res_ovf   = 1'b0;
                end else if (scan_end) begin
                    n_state     = ST_IDLE;
                    n_dv        = 1'b0;
                    n_res_valid = 1'b1;
                    if (full) begin
                        n_res_index = '0;
                        n_res_new   = 1'b0;
                        n_res_ovf   = 1'b1;
                    end else begin
                        n_res_index = IDX_W'(r_count);
                        n_res_new   = 1'b1;
                        n_res_ovf   = 1'b0;
                        n_count     = r_count + CW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_res_valid <= 1'b0;
            r_tol       <= TOL_W'(1);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && start) begin
            r_point.x <= i_point_x;
            r_point.y <= i_point_y;
        end
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_res_index <= n_res_index;
        r_res_new   <= n_res_new;
        r_res_ovf   <= n_res_ovf;
    end

    assign o_result_valid = r_res_valid;
    assign o_vertex_index = r_res_index;
    assign o_is_new       = r_res_new;
    assign o_overflow     = r_res_ovf;

    // a result only ever follows the end of a scan
    a_res_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_SCAN))
        else $error("result without a preceding scan");

    // overflow items carry index zero and are never new
    a_ovf_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_overflow) |-> (!o_is_new && (o_vertex_index == '0)))
        else $error("overflow item with bad fields");

    // the vertex count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("vertex count beyond store depth");

    // the count only grows, by one, together with a new-vertex result
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ((r_count == $past(r_count) + CW'(1)) && o_result_valid && o_is_new))
        else $error("vertex count changed without an append");

endmodule

// ----- test/weld_check_pkg.sv -----
package weld_check_pkg;

    import vdi_pkg::*;

    localparam int STORE_DEPTH = 256;

    typedef struct {
        logic [IDX_W-1:0] vertex_index;
        logic             is_new;
        logic             overflow;
    } t_weld_result;

    // Own copy of the vertex store, the fill level and the tolerance; predicts
    // the result of every accepted item and checks results in order.
    class vertex_weld_model;

        t_vertex          vertices [STORE_DEPTH];
        int unsigned      stored;
        logic [TOL_W-1:0] tolerance;
        t_weld_result     awaited [$];
        int               failures;

        function new();
            stored    = 0;
            tolerance = 1;
            failures  = 0;
        endfunction

        // First stored vertex within tolerance on both axes wins; else append
        function void note_point(logic signed [COORD_W-1:0] px,
                                 logic signed [COORD_W-1:0] py);
            t_weld_result r;
            bit           hit;
            longint       dx;
            longint       dy;
            r.vertex_index = '0;
            r.is_new       = 1'b0;
            r.overflow     = 1'b0;
            hit            = 1'b0;
            for (int unsigned k = 0; k < stored && !hit; k++) begin
                // differences at full width, so no wraparound
                dx = longint'(px) - longint'($signed(vertices[k].x));
                dy = longint'(py) - longint'($signed(vertices[k].y));
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx < longint'(tolerance) && dy < longint'(tolerance)) begin
                    r.vertex_index = k[IDX_W-1:0];
                    hit            = 1'b1;
                end
            end
            if (!hit) begin
                if (stored < STORE_DEPTH) begin
                    vertices[stored].x = px;
                    vertices[stored].y = py;
                    r.vertex_index     = stored[IDX_W-1:0];
                    r.is_new           = 1'b1;
                    stored++;
                end else begin
                    r.overflow = 1'b1;
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_result(logic [IDX_W-1:0] vertex_index, logic is_new,
                                   logic overflow);
            t_weld_result e;
            if (awaited.size() == 0) begin
                $error("result with no item outstanding: index %0d", vertex_index);
                failures++;
                return;
            end
            e = awaited.pop_front();
            if (vertex_index !== e.vertex_index) begin
                $error("vertex_index: expected %0d, got %0d", e.vertex_index, vertex_index);
                failures++;
            end
            if (is_new !== e.is_new) begin
                $error("is_new: expected %0d, got %0d", e.is_new, is_new);
                failures++;
            end
            if (overflow !== e.overflow) begin
                $error("overflow: expected %0d, got %0d", e.overflow, overflow);
                failures++;
            end
        endfunction

    endclass

endpackage

// ----- test/tb_top.sv -----
module tb_top;

    import vdi_pkg::*;
    import weld_check_pkg::*;

    // Generous ceiling: ~1100 items, each at worst a full-store scan plus a
    // sender gap, stay far below it.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 150;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      start          = 1'b0;
    logic                      busy;
    logic signed [COORD_W-1:0] i_point_x      = '0;
    logic signed [COORD_W-1:0] i_point_y      = '0;
    logic                      o_result_valid;
    logic        [IDX_W-1:0]   o_vertex_index;
    logic                      o_is_new;
    logic                      o_overflow;
    logic                      i_cfg_valid    = 1'b0;
    logic                      o_cfg_ready;
    logic        [TOL_W-1:0]   i_cfg_data     = '0;

    vertex_weld_model welder;
    bit               calm;       // when set the sender never pauses
    int               cycles;

    vertex_dedup_indexer_top #(
        .MAX_VERTICES(STORE_DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .o_result_valid (o_result_valid),
        .o_vertex_index (o_vertex_index),
        .o_is_new       (o_is_new),
        .o_overflow     (o_overflow),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitors: sample pre-edge values. An item noted in the same cycle as a
    // result goes to the back of the queue, so ordering is unaffected.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                welder.note_point(i_point_x, i_point_y);
            end
            if (o_result_valid) begin
                welder.check_result(o_vertex_index, o_is_new, o_overflow);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL vertex_dedup_indexer_top");
            $finish;
        end
    end

    // Offers one point and returns at the edge that takes it. start is left
    // high so a back-to-back item needs no toggle within one time step.
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            // half the time the pause is counted from the end of the scan,
            // otherwise it falls inside the scan
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge i_clk); while (busy);
            end
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and wait for every outstanding result. One edge first, so
    // an item taken at the calling edge is noted and seen busy.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || welder.awaited.size() != 0) @(posedge i_clk);
    endtask

    // Only called while idle, so the model is updated at the handshake edge
    task automatic write_tolerance(input logic [TOL_W-1:0] tol);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= tol;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        welder.tolerance = tol;
    endtask

    // Mostly inside the tolerance window, sometimes on or just past its edge
    function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] base,
                                                         int tol);
        int j;
        if (tol > 0 && $urandom_range(0, 4) != 0) begin
            j = int'($urandom_range(0, 2 * (tol - 1))) - (tol - 1);
        end else begin
            j = tol + int'($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 1) j = -j;
        end
        return base + j;
    endfunction

    // One random phase at a given tolerance. Most points re-use a stored
    // vertex (shared triangle corners), the rest are full-range noise.
    // With force_fill set the phase runs on until the store is full.
    task automatic weld_phase(input int tol, input bit force_fill);
        t_vertex                   v;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        settle();
        write_tolerance(tol[TOL_W-1:0]);
        for (int n = 0; n < PHASE_ITEMS || (force_fill && welder.stored < STORE_DEPTH);
             n++) begin
            if (n % 16 == 0) calm = ($urandom_range(0, 3) == 0);
            if (welder.stored > 0 && $urandom_range(0, 9) < 7) begin
                v = welder.vertices[$urandom_range(0, welder.stored - 1)];
                x = nudge(v.x, tol);
                y = nudge(v.y, tol);
            end else begin
                x = $urandom;
                y = $urandom;
            end
            send_point(x, y);
        end
    endtask

    initial begin
        welder = new();
        calm   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: exact matching at reset tolerance, coordinate extremes.
        // Max against min on an axis gives the widest difference there is.
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh0000_0001, 32'sh0000_0000);

        // A window of 1.0 in Q16.16: one LSB inside matches, exactly on it does not
        settle();
        write_tolerance(17'd65536);
        send_point(32'sh0000_FFFF, 32'shFFFF_0001);
        send_point(32'sh0001_0000, 32'sh0000_0000);
        send_point(32'sh7FFF_0001, 32'sh7FFF_0001);
        send_point(32'sh8001_0000, 32'sh8000_0000);

        // Zero tolerance: nothing matches, even an identical point
        settle();
        write_tolerance(17'd0);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh0000_0000, 32'sh0000_0000);

        // Register at all ones
        settle();
        write_tolerance(17'h1FFFF);
        send_point(32'sh0001_FFFE, -32'sh0001_FFFE);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh0002_0000, 32'sh0000_0000);

        // Random phases. The zero-tolerance phase fills the store, so the
        // later ones see a full store: matches and overflows only.
        weld_phase($urandom_range(2, 65535), 1'b0);
        weld_phase(1, 1'b0);
        weld_phase(65536, 1'b0);
        weld_phase(0, 1'b1);
        weld_phase(131071, 1'b0);
        weld_phase($urandom_range(1, 65536), 1'b0);

        settle();
        repeat (8) @(posedge i_clk);

        if (welder.failures == 0 && welder.awaited.size() == 0) begin
            $display("PASS vertex_dedup_indexer_top");
        end else begin
            if (welder.awaited.size() != 0) begin
                $error("%0d results never arrived", welder.awaited.size());
            end
            $display("FAIL vertex_dedup_indexer_top");
        end
        $finish;
    end

endmodule
